// ----- rtl/spq_pkg.sv -----
// package for the sorted priority queue: operation codes, command and result types
// no dependencies; used by every module of the block
package spq_pkg;

    localparam int DEF_DEPTH       = 16;
    localparam int DEF_VALUE_WIDTH = 32;
    localparam int CMDQ_DEPTH      = 2;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_SEARCH,
        OP_IGNORE
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [31:0]        value;
        logic signed [15:0] pri;
    } t_cmd;

    typedef struct packed {
        logic               accepted;
        logic [4:0]         found_position;
        logic [4:0]         entry_count;
        logic               is_empty_flag;
        logic [31:0]        head_value;
        logic signed [15:0] head_priority;
    } t_result;

endpackage

// ----- rtl/spq_front.sv -----
// front end: decodes the incoming operation into a command for the queue
// depends on spq_pkg
module spq_front import spq_pkg::*; (
    input  logic               i_valid,
    input  logic [1:0]         i_kind,
    input  logic [31:0]        i_item_value,
    input  logic signed [15:0] i_item_priority,
    output logic               o_push,
    output t_cmd               o_cmd
);

    always_comb begin
        o_cmd.value = i_item_value;
        o_cmd.pri   = i_item_priority;
        case (i_kind)
            KIND_INSERT: begin
                o_cmd.op = OP_INSERT;
            end
            KIND_REMOVE: begin
                o_cmd.op = OP_REMOVE;
            end
            KIND_SEARCH: begin
                o_cmd.op = OP_SEARCH;
            end
            default: begin
                o_cmd.op = OP_IGNORE;
            end
        endcase
    end

    assign o_push = i_valid;

endmodule

// ----- rtl/spq_cmd_fifo.sv -----
// short command queue between the front end and the cell row
// depends on spq_pkg
module spq_cmd_fifo import spq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    t_cmd             r_mem [CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_ready = (r_cnt != CNT_W'(CMDQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push_ok) begin
            n_wr = (r_wr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop_ok) begin
            n_rd = (r_rd == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ----- rtl/spq_back.sv -----
// back end: sorted row of cells that carries out insert, remove and search,
// plus the result register; depends on spq_pkg
module spq_back import spq_pkg::*; #(
    parameter int DEPTH       = DEF_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_ready
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_EXEC = 2'b01,
        ST_FIND = 2'b10
    } t_state;

    logic [VALUE_WIDTH-1:0] r_val [DEPTH];
    logic [VALUE_WIDTH-1:0] n_val [DEPTH];
    logic signed [15:0]     r_pri [DEPTH];
    logic signed [15:0]     n_pri [DEPTH];
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [DEPTH-1:0]       r_match, n_match;
    t_state                 r_state, n_state;
    logic                   r_res_valid, n_res_valid;
    t_result                r_res, n_res;

    logic [VALUE_WIDTH-1:0] key;
    logic [DEPTH-1:0]       match;
    logic [DEPTH-1:0]       higher;
    logic [DEPTH-1:0]       first_hit;
    logic [CNT_W-1:0]       found_idx;
    logic                   out_free;
    logic                   head_lower;
    logic                   full;
    logic                   emit;
    logic                   accepted;
    logic [CNT_W-1:0]       found;

    assign key        = VALUE_WIDTH'(i_cmd.value);
    assign out_free   = !r_res_valid || i_res_ready;
    assign full       = (r_cnt == CNT_W'(DEPTH));
    assign head_lower = (r_cnt == '0) || (r_pri[0] < i_cmd.pri);

    // per-cell compares, all in parallel
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            match[i]  = (CNT_W'(i) < r_cnt) && (r_val[i] == key);
            higher[i] = (CNT_W'(i) < r_cnt) && (r_pri[i] > i_cmd.pri);
        end
    end

    // lowest set bit of the registered match vector, then its 1-based index
    assign first_hit = r_match & (~r_match + 1'b1);

    always_comb begin
        found_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first_hit[i]) begin
                found_idx = found_idx | CNT_W'(i + 1);
            end
        end
    end

    always_comb begin
        n_val       = r_val;
        n_pri       = r_pri;
        n_cnt       = r_cnt;
        n_match     = r_match;
        n_state     = r_state;
        n_res_valid = r_res_valid && !i_res_ready;
        n_res       = r_res;
        o_cmd_pop   = 1'b0;
        emit        = 1'b0;
        accepted    = 1'b0;
        found       = '0;
        case (r_state)
            ST_EXEC: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        OP_INSERT: begin
                            emit = 1'b1;
                            if (!full) begin
                                accepted = 1'b1;
                                n_cnt    = r_cnt + 1'b1;
                                if (head_lower) begin
                                    n_val[0] = key;
                                    n_pri[0] = i_cmd.pri;
                                    for (int i = 1; i < DEPTH; i++) begin
                                        n_val[i] = r_val[i-1];
                                        n_pri[i] = r_pri[i-1];
                                    end
                                end else begin
                                    // head stays; new item lands after every higher entry
                                    for (int i = 1; i < DEPTH; i++) begin
                                        if (higher[i]) begin
                                            n_val[i] = r_val[i];
                                            n_pri[i] = r_pri[i];
                                        end else if (i == 1 || higher[i-1]) begin
                                            n_val[i] = key;
                                            n_pri[i] = i_cmd.pri;
                                        end else begin
                                            n_val[i] = r_val[i-1];
                                            n_pri[i] = r_pri[i-1];
                                        end
                                    end
                                end
                            end
                        end
                        OP_REMOVE: begin
                            emit = 1'b1;
                            if (r_cnt != '0) begin
                                accepted = 1'b1;
                                n_cnt    = r_cnt - 1'b1;
                                for (int i = 0; i < DEPTH - 1; i++) begin
                                    n_val[i] = r_val[i+1];
                                    n_pri[i] = r_pri[i+1];
                                end
                            end
                        end
                        OP_SEARCH: begin
                            n_match = match;
                            n_state = ST_FIND;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_FIND: begin
                if (out_free) begin
                    emit     = 1'b1;
                    accepted = 1'b1;
                    found    = found_idx;
                    n_state  = ST_EXEC;
                end
            end
            default: begin
                n_state = ST_EXEC;
            end
        endcase

        if (emit) begin
            n_res_valid          = 1'b1;
            n_res.accepted       = accepted;
            n_res.found_position = 5'(found);
            n_res.entry_count    = 5'(n_cnt);
            n_res.is_empty_flag  = (n_cnt == '0);
            if (n_cnt == '0) begin
                n_res.head_value    = '0;
                n_res.head_priority = '0;
            end else begin
                n_res.head_value    = 32'(n_val[0]);
                n_res.head_priority = n_pri[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_state     <= ST_EXEC;
            r_res_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_pri   <= n_pri;
        r_match <= n_match;
        r_res   <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ----- rtl/sorted_priority_queue_unit.sv -----
// path: insert and remove pass the command queue and result register, search also the
// registered match vector; throughput: one insert or remove per cycle while results are
// taken, a search holding the row for match-then-encode; a 2-entry queue absorbs stalls
// reset: synchronous active-low clears the entry count, command queue and result valid;
// cell contents stay undefined and are never shown, so no clearing pass is needed
module sorted_priority_queue_unit import spq_pkg::*; #(
    parameter int DEPTH       = DEF_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_item_value,
    input  logic signed [15:0] i_item_priority,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_accepted,
    output logic [4:0]         o_found_position,
    output logic [4:0]         o_entry_count,
    output logic               o_is_empty_flag,
    output logic signed [31:0] o_head_value,
    output logic signed [15:0] o_head_priority
);

    logic    push;
    t_cmd    front_cmd;
    logic    cmd_valid;
    t_cmd    cmd;
    logic    cmd_pop;
    t_result res;

    spq_front u_front (
        .i_valid         (i_valid),
        .i_kind          (i_kind),
        .i_item_value    ($unsigned(i_item_value)),
        .i_item_priority (i_item_priority),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    spq_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_ready (o_ready),
        .o_valid (cmd_valid),
        .o_cmd   (cmd),
        .i_pop   (cmd_pop)
    );

    spq_back #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (o_valid),
        .o_res       (res),
        .i_res_ready (i_ready)
    );

    assign o_accepted       = res.accepted;
    assign o_found_position = res.found_position;
    assign o_entry_count    = res.entry_count;
    assign o_is_empty_flag  = res.is_empty_flag;
    assign o_head_value     = $signed(res.head_value);
    assign o_head_priority  = res.head_priority;

endmodule
